// ----- rtl/btpt_pkg.sv -----
// btpt_pkg: shared types, flag positions, register indexes and reset values
// for the button and protection tick timers
// no dependencies
package btpt_pkg;

   // flag word layout
   localparam int FLAG_W        = 9;
   localparam int FLAG_PRESS    = 0;
   localparam int FLAG_CLICK    = 1;
   localparam int FLAG_LONG     = 2;
   localparam int FLAG_DIS_EN   = 3;
   localparam int FLAG_DIS_DONE = 4;
   localparam int FLAG_CHG_EN   = 5;
   localparam int FLAG_CHG_DONE = 6;
   localparam int FLAG_CHG_HOLD = 7;
   localparam int FLAG_SECOND   = 8;

   // flags that only a write clears
   localparam logic [FLAG_W-1:0] STICKY_MASK = 9'b1_0101_0110;

   // counters and registers
   localparam int CNT_W   = 8;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_W-1:0] CLICK_TICKS_RST   = 8'd12;
   localparam logic [CSR_W-1:0] LONG_TICKS_RST    = 8'd100;
   localparam logic [CSR_W-1:0] RELEASE_TICKS_RST = 8'd100;
   localparam logic [CSR_W-1:0] HOLD_TICKS_RST    = 8'd20;
   localparam logic [CSR_W-1:0] SECOND_TICKS_RST  = 8'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLICK_TICKS   = 3'd0,
      CSR_LONG_TICKS    = 3'd1,
      CSR_RELEASE_TICKS = 3'd2,
      CSR_HOLD_TICKS    = 3'd3,
      CSR_SECOND_TICKS  = 3'd4
   } csr_index_type;

   // request kinds carried on tuser
   localparam logic REQ_TICK  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   // stream widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   // classified command
   typedef struct packed {
      logic              is_write;
      logic              button_down;
      logic [FLAG_W-1:0] set_bits;
      logic [FLAG_W-1:0] clear_bits;
   } cmd_type;

endpackage

// ----- rtl/btpt_front.sv -----
// btpt_front: accepts request words, unpacks and classifies them into commands
// depends on btpt_pkg
module btpt_front
   import btpt_pkg::*;
(
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   req_tuser,
   input  logic                   q_ready,
   output logic                   q_push,
   output cmd_type                q_cmd
);

   // accept whenever the queue has room
   assign req_tready = q_ready;
   assign q_push     = req_tvalid & q_ready;

   // unpack and classify: a tick carries no masks, a write ignores the button
   always_comb begin
      q_cmd = '0;
      unique case (req_tuser)
         REQ_WRITE: begin
            q_cmd.is_write   = 1'b1;
            q_cmd.set_bits   = req_tdata[FLAG_W:1];
            q_cmd.clear_bits = req_tdata[2*FLAG_W:FLAG_W+1];
         end
         REQ_TICK: begin
            q_cmd.button_down = req_tdata[0];
         end
         default: q_cmd = '0;
      endcase
   end

endmodule

// ----- rtl/btpt_queue.sv -----
// btpt_queue: two-entry command queue between front and back
// depends on btpt_pkg
module btpt_queue
   import btpt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   cmd_type                q_mem [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = q_mem[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) q_mem[wr_ptr_ff] <= push_cmd;
   end

`ifndef SYNTHESIS
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH)) |-> !push)
      else $error("queue written while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> !pop)
      else $error("queue read while empty");
`endif

endmodule

// ----- rtl/btpt_back.sv -----
// btpt_back: configuration registers, flag word, tick counters and result register
// depends on btpt_pkg
module btpt_back
   import btpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata,
   input  logic                   q_valid,
   input  cmd_type                q_cmd,
   output logic                   q_pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   logic [CSR_W-1:0]  click_max_ff, long_ticks_ff, release_ticks_ff;
   logic [CSR_W-1:0]  hold_ticks_ff, second_ticks_ff;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   logic [CNT_W-1:0]  press_ff, press_in;
   logic [CNT_W-1:0]  dis_ff, dis_in;
   logic [CNT_W-1:0]  chg_ff, chg_in;
   logic [CNT_W-1:0]  hold_ff, hold_in;
   logic [CNT_W-1:0]  sec_ff, sec_in;
   logic [CNT_W-1:0]  dis_inc, chg_inc, hold_inc, sec_inc;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [FLAG_W-1:0] rsp_status_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         click_max_ff     <= CLICK_TICKS_RST;
         long_ticks_ff    <= LONG_TICKS_RST;
         release_ticks_ff <= RELEASE_TICKS_RST;
         hold_ticks_ff    <= HOLD_TICKS_RST;
         second_ticks_ff  <= SECOND_TICKS_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CLICK_TICKS:   click_max_ff     <= csr_wdata;
            CSR_LONG_TICKS:    long_ticks_ff    <= csr_wdata;
            CSR_RELEASE_TICKS: release_ticks_ff <= csr_wdata;
            CSR_HOLD_TICKS:    hold_ticks_ff    <= csr_wdata;
            CSR_SECOND_TICKS:  second_ticks_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // take a command when the result register is free or being emptied
   assign q_pop = q_valid && (!rsp_valid_ff || rsp_tready);

   assign dis_inc  = dis_ff + 1'b1;
   assign chg_inc  = chg_ff + 1'b1;
   assign hold_inc = hold_ff + 1'b1;
   assign sec_inc  = sec_ff + 1'b1;

   // flag word and counter update for one command
   always_comb begin
      flags_in = flags_ff;
      press_in = press_ff;
      dis_in   = dis_ff;
      chg_in   = chg_ff;
      hold_in  = hold_ff;
      sec_in   = sec_ff;
      if (q_cmd.is_write) begin
         flags_in = (flags_ff & ~q_cmd.clear_bits) | q_cmd.set_bits;
      end else begin
         // press timing
         if (flags_ff[FLAG_PRESS]) begin
            if (q_cmd.button_down) begin
               if (press_ff >= long_ticks_ff) begin
                  flags_in[FLAG_LONG]  = 1'b1;
                  flags_in[FLAG_PRESS] = 1'b0;
                  press_in             = '0;
               end else begin
                  press_in = press_ff + 1'b1;
               end
            end else begin
               if (press_ff <= click_max_ff) flags_in[FLAG_CLICK] = 1'b1;
               flags_in[FLAG_PRESS] = 1'b0;
               press_in             = '0;
            end
         end else begin
            press_in = '0;
         end
         // discharge overcurrent release
         if (flags_ff[FLAG_DIS_EN]) begin
            if (dis_inc >= release_ticks_ff) begin
               flags_in[FLAG_DIS_DONE] = 1'b1;
               flags_in[FLAG_DIS_EN]   = 1'b0;
               dis_in                  = '0;
            end else begin
               dis_in = dis_inc;
            end
         end else begin
            dis_in = '0;
         end
         // charge overcurrent release
         if (flags_ff[FLAG_CHG_EN]) begin
            if (chg_inc >= release_ticks_ff) begin
               flags_in[FLAG_CHG_DONE] = 1'b1;
               flags_in[FLAG_CHG_EN]   = 1'b0;
               chg_in                  = '0;
            end else begin
               chg_in = chg_inc;
            end
         end else begin
            chg_in = '0;
         end
         // retry hold expiry
         if (flags_ff[FLAG_CHG_HOLD]) begin
            if (hold_inc >= hold_ticks_ff) begin
               flags_in[FLAG_CHG_HOLD] = 1'b0;
               hold_in                 = '0;
            end else begin
               hold_in = hold_inc;
            end
         end else begin
            hold_in = '0;
         end
         // one-second prescaler
         if (sec_inc >= second_ticks_ff) begin
            flags_in[FLAG_SECOND] = 1'b1;
            sec_in                = '0;
         end else begin
            sec_in = sec_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
         press_ff <= '0;
         dis_ff   <= '0;
         chg_ff   <= '0;
         hold_ff  <= '0;
         sec_ff   <= '0;
      end else if (q_pop) begin
         flags_ff <= flags_in;
         press_ff <= press_in;
         dis_ff   <= dis_in;
         chg_ff   <= chg_in;
         hold_ff  <= hold_in;
         sec_ff   <= sec_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (q_pop) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop) rsp_status_ff <= flags_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-FLAG_W){1'b0}}, rsp_status_ff};

`ifndef SYNTHESIS
   a_press_count_cleared: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_cmd.is_write && !flags_ff[FLAG_PRESS]) |=> (press_ff == '0))
      else $error("press counter kept while no press pending");
   a_tick_keeps_sticky: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_cmd.is_write) |=>
         ((($past(flags_ff) & STICKY_MASK) & ~flags_ff) == '0))
      else $error("tick cleared a sticky flag");
   a_result_matches_flags: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (rsp_valid_ff && (rsp_status_ff == flags_ff)))
      else $error("result word differs from flag word");
`endif

endmodule

// ----- rtl/button_and_protection_tick_timers_top.sv -----
// button_and_protection_tick_timers_top: top level of the tick timers
// depends on btpt_pkg, btpt_front, btpt_queue, btpt_back

// Tick-driven status timer. Each request word is either a tick (tuser low,
// button level in tdata bit 0) or a flag write (tuser high, set and clear
// masks in tdata); every word returns one response word holding the 9-bit
// flag word after it. One word is taken per clock in steady flow while the
// response side does not stall: the whole tick update of the flag word and
// its five counters is combinational in the back unit, so the rate is one
// word per clock. A request is written into the two-entry command queue
// when accepted and moves into the result register once that register is
// free or being emptied. While the response side stalls, the queue and
// the result register hold three words before req_tready drops. The user
// must write registers through the csr port only while no words are in
// flight; the block itself does not enforce this.
module button_and_protection_tick_timers_top
   import btpt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // request stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // button_down, set_bits[8:0], clear_bits[8:0], zero pad
   input  logic                   req_tuser,  // req_type
   // response stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // status[8:0], zero pad
   // register write port
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]       csr_wdata
);

   logic    q_ready;
   logic    q_push;
   cmd_type q_in_cmd;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_out_cmd;

   // classify incoming words
   btpt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_cmd      (q_in_cmd)
   );

   // decouple front and back
   btpt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_in_cmd),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_cmd    (q_out_cmd)
   );

   // execute commands and hold the result
   btpt_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (q_valid),
      .q_cmd      (q_out_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
